### sv/tlm_pkg.sv
// ----------------------------------------------------------------------------
// tlm_pkg
// Shared types and defaults for the tick lateness monitor: request kinds,
// the packed input beat and the packed result beat.
// ----------------------------------------------------------------------------
`default_nettype none

package tlm_pkg;

	// default sizing
	localparam int BUCKETS_DEF   = 32;
	localparam int TIME_BITS_DEF = 32;

	// request kinds carried on the input tuser
	typedef enum logic {
		REQ_TICK = 1'b0,
		REQ_READ = 1'b1
	} req_kind_t;

	// input beat payload, lowest field last
	typedef struct packed {
		logic [2:0]  pad;
		logic [4:0]  read_bucket;
		logic [31:0] now_ms;
		logic [31:0] tick_period_ms;
	} in_data_t;

	// result beat payload, lowest field last
	typedef struct packed {
		logic [1:0]  pad;
		logic [31:0] bucket_value;
		logic [31:0] late_decay_ms;
		logic [31:0] late_max_ms;
		logic [31:0] late_total_ms;
		logic [31:0] late_total_count;
		logic [31:0] tick_total;
		logic [4:0]  bucket_hit;
		logic [31:0] late_by_ms;
		logic        was_late;
		logic [31:0] delay_ms;
	} result_t;

	localparam int IN_DATA_BITS  = $bits(in_data_t);
	localparam int OUT_DATA_BITS = $bits(result_t);

endpackage

`default_nettype wire

### sv/tlm_core.sv
// ----------------------------------------------------------------------------
// tlm_core
// Scheduler state, lateness statistics and histogram. Works out the result
// for one request combinationally and commits the new state on commit.
// ----------------------------------------------------------------------------
`default_nettype none

module tlm_core #(
	parameter int BUCKETS   = tlm_pkg::BUCKETS_DEF,
	parameter int TIME_BITS = tlm_pkg::TIME_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               commit,
	input  wire tlm_pkg::req_kind_t req_type,
	input  wire tlm_pkg::in_data_t  req_data,
	output tlm_pkg::result_t        result
);

	localparam int IDXW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam logic [6:0] LAST_BUCKET = 7'(BUCKETS - 1);
	localparam logic [6:0] BUCKET_COUNT = 7'(BUCKETS);

	// state
	logic [TIME_BITS-1:0] sched_q;
	logic [31:0]          ticks_q;
	logic [31:0]          lates_q;
	logic [31:0]          sum_q;
	logic [31:0]          peak_q;
	logic [31:0]          avg_q;
	logic [31:0]          hist_q [BUCKETS];

	// next-state values
	logic [TIME_BITS-1:0] sched_d;
	logic [31:0]          ticks_d;
	logic [31:0]          lates_d;
	logic [31:0]          sum_d;
	logic [31:0]          peak_d;
	logic [31:0]          avg_d;
	logic                 hist_we;
	logic [IDXW-1:0]      hist_idx;
	logic [31:0]          hist_inc;

	// highest set bit, zero for values below two
	function automatic logic [6:0] floor_log2(input logic [TIME_BITS-1:0] v);
		logic [6:0] n;
		n = '0;
		for (int i = 1; i < TIME_BITS; i++) begin
			if (v[i]) n = 7'(i);
		end
		return n;
	endfunction

	// one request through the scheduler and statistics
	always_comb begin
		logic signed [TIME_BITS-1:0] per_ext;
		logic [TIME_BITS-1:0] now_ext;
		logic [TIME_BITS-1:0] base;
		logic [TIME_BITS-1:0] next_sched;
		logic [TIME_BITS-1:0] dur;
		logic [31:0]          dur32;
		logic [6:0]           lg;
		logic [6:0]           bkt;
		logic [6:0]           rb_ext;
		logic                 late;

		per_ext    = TIME_BITS'($signed(req_data.tick_period_ms));
		now_ext    = TIME_BITS'(req_data.now_ms);
		base       = (sched_q == '0) ? now_ext : sched_q;
		next_sched = base + per_ext;
		late       = next_sched < now_ext;
		dur        = now_ext - next_sched;
		dur32      = 32'(dur);
		lg         = floor_log2(dur);
		bkt        = (lg > LAST_BUCKET) ? LAST_BUCKET : lg;
		rb_ext     = {2'b00, req_data.read_bucket};

		sched_d  = sched_q;
		ticks_d  = ticks_q;
		lates_d  = lates_q;
		sum_d    = sum_q;
		peak_d   = peak_q;
		avg_d    = avg_q;
		hist_we  = 1'b0;
		hist_idx = rb_ext[IDXW-1:0];
		hist_inc = '0;

		result                  = '0;

		if (req_type == tlm_pkg::REQ_TICK) begin
			ticks_d = ticks_q + 32'd1;
			avg_d   = avg_q >> 1;
			sched_d = next_sched;
			if (late) begin
				hist_idx = bkt[IDXW-1:0];
				hist_inc = hist_q[hist_idx] + 32'd1;
				hist_we  = 1'b1;
				lates_d  = lates_q + 32'd1;
				sum_d    = sum_q + dur32;
				avg_d    = (avg_q >> 1) + dur32;
				peak_d   = (dur32 > peak_q) ? dur32 : peak_q;
				sched_d  = now_ext;
				result.was_late     = 1'b1;
				result.late_by_ms   = dur32;
				result.bucket_hit   = bkt[4:0];
				result.bucket_value = hist_inc;
			end
			result.delay_ms = 32'(sched_d - now_ext);
		end else begin
			if (rb_ext < BUCKET_COUNT) result.bucket_value = hist_q[hist_idx];
		end

		result.tick_total       = ticks_d;
		result.late_total_count = lates_d;
		result.late_total_ms    = sum_d;
		result.late_max_ms      = peak_d;
		result.late_decay_ms    = avg_d;
	end

	// scalar state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sched_q <= '0;
			ticks_q <= '0;
			lates_q <= '0;
			sum_q   <= '0;
			peak_q  <= '0;
			avg_q   <= '0;
		end else if (commit) begin
			sched_q <= sched_d;
			ticks_q <= ticks_d;
			lates_q <= lates_d;
			sum_q   <= sum_d;
			peak_q  <= peak_d;
			avg_q   <= avg_d;
		end
	end

	// histogram bins, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BUCKETS; i++) hist_q[i] <= '0;
		end else if (commit && hist_we) begin
			hist_q[hist_idx] <= hist_inc;
		end
	end

endmodule

`default_nettype wire

### sv/tick_lateness_monitor_unit.sv
// ----------------------------------------------------------------------------
// tick_lateness_monitor_unit
// Stream wrapper around the tick lateness monitor: input register, single
// pass evaluation and an output register.
// ----------------------------------------------------------------------------
// Each request beat (tick or histogram read) yields exactly one result beat.
// The unit takes one request per clock cycle with no gaps while the master
// side is ready. A request sits in the input register while the scheduler
// state, statistics and histogram bin are evaluated. The state is updated and
// the result loaded into the output register when the request advances, which
// waits while an earlier result is stalled on m_tready; m_tvalid rises once
// the result is in the output register. While a finished result waits on
// m_tready, one more request can enter the input register; s_tready then
// stays low until the master side takes the waiting beat. No beat is lost
// while stalled. All statistics and the histogram clear at reset.
`default_nettype none

module tick_lateness_monitor_unit #(
	parameter int BUCKETS   = tlm_pkg::BUCKETS_DEF,
	parameter int TIME_BITS = tlm_pkg::TIME_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// tick_period_ms[31:0], now_ms[63:32], read_bucket[68:64], zero pad
	input  wire logic [tlm_pkg::IN_DATA_BITS-1:0]   s_tdata,
	// req_type
	input  wire logic                               s_tuser,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// delay_ms[31:0], was_late[32], late_by_ms[64:33], bucket_hit[69:65],
	// tick_total[101:70], late_total_count[133:102], late_total_ms[165:134],
	// late_max_ms[197:166], late_decay_ms[229:198], bucket_value[261:230], pad
	output logic [tlm_pkg::OUT_DATA_BITS-1:0]       m_tdata
);

	logic               valid_s1;
	tlm_pkg::in_data_t  data_s1;
	tlm_pkg::req_kind_t kind_s1;
	logic               out_valid_q;
	tlm_pkg::result_t   out_q;
	tlm_pkg::result_t   result;
	logic               advance;

	// move the held request into the output register
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1 <= tlm_pkg::in_data_t'(s_tdata);
			kind_s1 <= tlm_pkg::req_kind_t'(s_tuser);
		end
	end

	// evaluation and state
	tlm_core #(
		.BUCKETS   (BUCKETS),
		.TIME_BITS (TIME_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.commit   (advance),
		.req_type (kind_s1),
		.req_data (data_s1),
		.result   (result)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) out_q <= result;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

endmodule

`default_nettype wire
